FILE: sv/scfc_pkg.sv
// scfc_pkg: marker constants, status codes, phase type and crc step function
// for the sync frame checker; no dependencies

package scfc_pkg;

  localparam logic [7:0] SOF0     = 8'hAA;
  localparam logic [7:0] SOF1     = 8'hBB;
  localparam logic [7:0] EOF0     = 8'hCC;
  localparam logic [7:0] EOF1     = 8'hDD;
  localparam logic [7:0] CRC_POLY = 8'hA6;
  localparam logic [7:0] MIN_LEN  = 8'd12;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SOF = 2'd1,
    ST_SHORT   = 2'd2,
    ST_BAD_EOF = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'b01,
    PH_FRAME = 2'b10
  } phase_t;

  // eight msb-first bit steps of the remainder
  function automatic logic [7:0] crc_byte(input logic [7:0] rem, input logic [7:0] din);
    logic [7:0] r;
    r = rem;
    for (int b = 7; b >= 0; b--) begin
      if (r[7]) begin
        r = r ^ CRC_POLY;
      end
      r = {r[6:0], din[b]};
    end
    return r;
  endfunction

endpackage

FILE: sv/scfc_stream_if.sv
// scfc_in_if / scfc_out_if: valid-ready channels of the sync frame checker
// depends on scfc_pkg

interface scfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface scfc_out_if
  import scfc_pkg::*;
;
  logic       valid;
  logic       ready;
  status_t    status;
  logic [7:0] frame_length;
  logic [5:0] crc_computed;
  logic [7:0] crc_received;

  modport source (output valid, output status, output frame_length,
                  output crc_computed, output crc_received, input ready);
  modport sink   (input valid, input status, input frame_length,
                  input crc_computed, input crc_received, output ready);
endinterface

FILE: sv/sync_frame_checker_crc6_top.sv
// sync_frame_checker_crc6_top: frame marker/length check, crc6 over length byte and body
// depends on scfc_pkg, scfc_in_if, scfc_out_if
//
//   channel   dir  payload                                              role
//   in_ch     in   data_byte[7:0], first                                one byte per transaction
//   out_ch    out  status[1:0], frame_length[7:0], crc_computed[5:0],   one per decision
//                  crc_received[7:0]
//
// one byte per cycle sustained while the output is not stalled; a byte is held in
// the input register, and its decision (if any) is registered into the output register
// the crc update is eight unrolled xor steps between the input register and state
// synchronous active-low reset returns the checker to idle and empties both registers
// a stalled output holds the input register, and in_ch.ready drops once it is full

module sync_frame_checker_crc6_top
  import scfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  scfc_in_if.sink    in_ch,
  scfc_out_if.source out_ch
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic       mark_r, mark_nxt;

  logic       out_vld_r;
  status_t    out_status_r;
  logic [7:0] out_len_r;
  logic [5:0] out_crc_r;
  logic [7:0] out_rx_r;

  logic       go;
  logic       res_vld;
  status_t    res_status;
  logic       active;
  logic [7:0] pos;
  logic [7:0] len_m4, len_m3, len_m2;

  assign go          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || go;

  assign len_m4 = len_r - 8'd4;
  assign len_m3 = len_r - 8'd3;
  assign len_m2 = len_r - 8'd2;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    seen_nxt   = seen_r;
    mark_nxt   = mark_r;
    res_vld    = 1'b0;
    res_status = ST_OK;
    active     = in_first_r || (phase_r == PH_FRAME);
    pos        = in_first_r ? 8'd0 : cnt_r;
    if (go && active) begin
      phase_nxt = PH_FRAME;
      cnt_nxt   = pos + 8'd1;
      priority if (pos == 8'd0) begin
        mark_nxt = (in_byte_r == SOF0);
      end else if (pos == 8'd1) begin
        if (!(mark_r && in_byte_r == SOF1)) begin
          res_vld    = 1'b1;
          res_status = ST_BAD_SOF;
        end
      end else if (pos == 8'd2) begin
        if (in_byte_r < MIN_LEN) begin
          res_vld    = 1'b1;
          res_status = ST_SHORT;
        end else begin
          len_nxt = in_byte_r;
          rem_nxt = in_byte_r;
        end
      end else if (pos <= len_m4) begin
        rem_nxt = crc_byte(rem_r, in_byte_r);
      end else if (pos == len_m3) begin
        rem_nxt  = crc_byte(rem_r, 8'd0);
        seen_nxt = in_byte_r;
      end else if (pos == len_m2) begin
        mark_nxt = (in_byte_r == EOF0);
      end else begin
        res_vld    = 1'b1;
        res_status = (mark_r && in_byte_r == EOF1) ? ST_OK : ST_BAD_EOF;
      end
      if (res_vld) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      phase_r   <= PH_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (go) begin
        in_vld_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      if (go && res_vld) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r  <= in_ch.data_byte;
      in_first_r <= in_ch.first;
    end
    cnt_r  <= cnt_nxt;
    len_r  <= len_nxt;
    rem_r  <= rem_nxt;
    seen_r <= seen_nxt;
    mark_r <= mark_nxt;
    if (go && res_vld) begin
      out_status_r <= res_status;
      if (res_status == ST_OK) begin
        out_len_r <= len_r;
        out_crc_r <= rem_r[7:2];
        out_rx_r  <= seen_r;
      end else begin
        out_len_r <= 8'd0;
        out_crc_r <= 6'd0;
        out_rx_r  <= 8'd0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.crc_computed = out_crc_r;
  assign out_ch.crc_received = out_rx_r;

`ifndef SYNTHESIS
  a_err_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r != ST_OK |-> out_len_r == 8'd0 && out_rx_r == 8'd0)
    else $error("error result carries nonzero payload");

  a_ok_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r == ST_OK |-> out_len_r >= MIN_LEN)
    else $error("ok result with short length");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    go && res_vld |=> phase_r == PH_IDLE)
    else $error("checker not idle after decision");

  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_vld_r && out_vld_r && !out_ch.ready)
    else $error("input stalled without output backpressure");
`endif

endmodule

FILE: dv/sync_frame_checker_crc6_top_tb.sv
// sync_frame_checker_crc6_top_tb: random and directed frame traffic with a scoreboard
// that predicts each status transaction; bursty sender, stalling receiver
// depends on scfc_pkg, scfc_in_if, scfc_out_if and sync_frame_checker_crc6_top

module sync_frame_checker_crc6_top_tb;
  import scfc_pkg::*;

  localparam int ITEM_TARGET  = 1250;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    status_t    status;
    logic [7:0] frame_length;
    logic [5:0] crc_computed;
    logic [7:0] crc_received;
  } frame_verdict_t;

  typedef enum int {FK_GOOD, FK_BAD_SOF, FK_SHORT, FK_BAD_EOF, FK_CUT, FK_NOISE, FK_JUNK}
    frame_kind_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  class frame_verdict_board;
    frame_verdict_t expected_verdicts[$];
    int             errors;
    bit             in_frame;
    logic [7:0]     next_pos;
    logic [7:0]     frame_len;
    logic [7:0]     remainder;
    logic [7:0]     crc_rx;
    bit             marker_seen;

    function new();
      errors      = 0;
      in_frame    = 0;
      next_pos    = '0;
      frame_len   = '0;
      remainder   = '0;
      crc_rx      = '0;
      marker_seen = 0;
    endfunction

    // shift and feedback folded together: (r ^ p) << 1 == (r << 1) ^ (p << 1)
    function logic [7:0] crc_shift(logic [7:0] rem, logic [7:0] din);
      logic [7:0] acc;
      acc = rem;
      for (int i = 7; i >= 0; i--) begin
        acc = {acc[6:0], din[i]} ^ (acc[7] ? {CRC_POLY[6:0], 1'b0} : 8'h00);
      end
      return acc;
    endfunction

    function void decide(status_t st, logic [7:0] len, logic [5:0] crc, logic [7:0] rx);
      frame_verdict_t v;
      v.status       = st;
      v.frame_length = len;
      v.crc_computed = crc;
      v.crc_received = rx;
      expected_verdicts.push_back(v);
      in_frame = 0;
    endfunction

    // returns 1 when the byte is taken into a frame, 0 when the checker ignores it
    function bit note_byte(logic [7:0] data, logic first);
      logic [7:0] at;
      if (first) begin
        in_frame    = 1;
        next_pos    = '0;
        frame_len   = '0;
        remainder   = '0;
        crc_rx      = '0;
        marker_seen = 0;
      end else if (!in_frame) begin
        return 0;
      end
      at       = next_pos;
      next_pos = next_pos + 8'd1;
      if (at == 8'd0) begin
        marker_seen = (data == SOF0);
      end else if (at == 8'd1) begin
        if (!(marker_seen && data == SOF1)) begin
          decide(ST_BAD_SOF, '0, '0, '0);
        end
      end else if (at == 8'd2) begin
        if (data < MIN_LEN) begin
          decide(ST_SHORT, '0, '0, '0);
        end else begin
          frame_len = data;
          remainder = data;
        end
      end else if (at <= frame_len - 8'd4) begin
        remainder = crc_shift(remainder, data);
      end else if (at == frame_len - 8'd3) begin
        remainder = crc_shift(remainder, 8'h00);
        crc_rx    = data;
      end else if (at == frame_len - 8'd2) begin
        marker_seen = (data == EOF0);
      end else if (!(marker_seen && data == EOF1)) begin
        decide(ST_BAD_EOF, '0, '0, '0);
      end else begin
        decide(ST_OK, frame_len, remainder[7:2], crc_rx);
      end
      return 1;
    endfunction

    function void check_verdict(status_t st, logic [7:0] len, logic [5:0] crc,
                                logic [7:0] rx);
      frame_verdict_t v;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected transaction: status %0d, frame_length %0d", st, len);
        errors++;
        return;
      end
      v = expected_verdicts.pop_front();
      if (st !== v.status) begin
        $error("status: expected %0d, actual %0d", v.status, st);
        errors++;
      end
      if (len !== v.frame_length) begin
        $error("frame_length: expected %0d, actual %0d", v.frame_length, len);
        errors++;
      end
      if (crc !== v.crc_computed) begin
        $error("crc_computed: expected %0d, actual %0d", v.crc_computed, crc);
        errors++;
      end
      if (rx !== v.crc_received) begin
        $error("crc_received: expected %0d, actual %0d", v.crc_received, rx);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  scfc_in_if  in_ch ();
  scfc_out_if out_ch ();

  sync_frame_checker_crc6_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_verdict_board board;
  int cycle_count;
  int items_taken;
  int burst_left;
  bit steady_sender;
  int hold_requests;
  int holds_served;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sync_frame_checker_crc6_top_tb: FAIL");
    $finish;
  end

  initial begin : receiver
    rx_mode_t mode;
    int left;
    int tick;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    tick = 0;
    holds_served = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        // long hold-off so the checker fills and backs up its input
        holds_served = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(50, 300);
        end
        left--;
        tick++;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 9) != 0);
          default:   out_ch.ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_verdict(out_ch.status, out_ch.frame_length, out_ch.crc_computed,
                          out_ch.crc_received);
    end
  end

  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    if (r == v) begin
      r = ~v;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 84) begin
      return 8'($urandom_range(MIN_LEN, 40));
    end else if (roll < 93) begin
      return 8'($urandom_range(41, 127));
    end
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic offer_byte(input logic [7:0] data, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.first     <= first;
    do @(posedge clk); while (!in_ch.ready);
    void'(board.note_byte(data, first));
    items_taken++;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] bytes[$];
    logic [7:0] len;
    int pick;
    int count;
    len = (kind == FK_SHORT) ? 8'($urandom_range(0, MIN_LEN - 1)) : pick_length();
    if (kind == FK_NOISE || kind == FK_JUNK) begin
      count = (kind == FK_NOISE) ? $urandom_range(1, 4) : $urandom_range(1, 16);
      repeat (count) bytes.push_back(8'($urandom_range(0, 255)));
      if (kind == FK_JUNK && $urandom_range(0, 1) == 1) begin
        bytes[0] = SOF0;
      end
    end else begin
      bytes.push_back(SOF0);
      bytes.push_back(SOF1);
      bytes.push_back(len);
      if (kind != FK_SHORT) begin
        while (bytes.size() < int'(len) - 2) bytes.push_back(8'($urandom_range(0, 255)));
        bytes.push_back(EOF0);
        bytes.push_back(EOF1);
      end
    end
    pick = $urandom_range(0, 2);
    case (kind)
      FK_BAD_SOF: begin
        if (pick != 1) bytes[0] = other_than(SOF0);
        if (pick != 0) bytes[1] = other_than(SOF1);
      end
      FK_BAD_EOF: begin
        if (pick != 1) bytes[len - 2] = other_than(EOF0);
        if (pick != 0) bytes[len - 1] = other_than(EOF1);
      end
      FK_CUT: begin
        count = $urandom_range(1, len - 1);
        while (bytes.size() > count) void'(bytes.pop_back());
      end
      default: ;
    endcase
    foreach (bytes[i]) begin
      offer_byte(bytes[i], (i == 0) && (kind != FK_NOISE));
    end
  endtask

  initial begin : stimulus
    logic [7:0] good12[12];
    logic [7:0] bad_end12[12];
    int roll;
    bit pressure_done;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.first     = 1'b0;
    board           = new();
    items_taken     = 0;
    burst_left      = 0;
    steady_sender   = 0;
    hold_requests   = 0;
    pressure_done   = 0;
    good12    = '{SOF0, SOF1, MIN_LEN, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h5A, 8'hFF,
                  EOF0, EOF1};
    bad_end12 = '{SOF0, SOF1, MIN_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  EOF0, EOF0};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle byte, both start marker bytes, short length, restart, good,
    // ignored byte after a decision, bad end marker
    offer_byte(8'h55, 1'b0);
    offer_byte(8'h00, 1'b1);
    offer_byte(SOF1, 1'b0);
    offer_byte(SOF0, 1'b1);
    offer_byte(8'hFF, 1'b0);
    offer_byte(SOF0, 1'b1);
    offer_byte(SOF1, 1'b0);
    offer_byte(MIN_LEN - 8'd1, 1'b0);
    offer_byte(SOF0, 1'b1);
    offer_byte(SOF1, 1'b0);
    foreach (good12[i]) offer_byte(good12[i], i == 0);
    offer_byte(EOF1, 1'b0);
    foreach (bad_end12[i]) offer_byte(bad_end12[i], i == 0);

    while (items_taken < ITEM_TARGET) begin
      if (!pressure_done && items_taken >= ITEM_TARGET / 2) begin
        pressure_done = 1;
        hold_requests++;
        steady_sender = 1;
        burst_left    = 0;
        repeat (3) send_frame(FK_BAD_SOF);
        steady_sender = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        steady_sender = !steady_sender;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55)      send_frame(FK_GOOD);
      else if (roll < 63) send_frame(FK_BAD_SOF);
      else if (roll < 71) send_frame(FK_SHORT);
      else if (roll < 80) send_frame(FK_BAD_EOF);
      else if (roll < 88) send_frame(FK_CUT);
      else if (roll < 94) send_frame(FK_NOISE);
      else                send_frame(FK_JUNK);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (board.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("sync_frame_checker_crc6_top_tb: PASS");
    end else begin
      $display("sync_frame_checker_crc6_top_tb: FAIL");
    end
    $finish;
  end

endmodule
